### design/tsct_pkg.sv
// Shared widths, constants and lookup functions for the Taylor sine/cosine/tangent block.
`timescale 1ns / 1ps
`default_nettype none

package tsct_pkg;

    localparam int FRAC_BITS = 14;

    // Port field widths
    localparam int ANGLE_W = 22;
    localparam int TRIG_W  = 18;
    localparam int TAN_W   = 32;

    // Internal widths
    localparam int X_W     = ANGLE_W + 2;          // reduction work width
    localparam int A_W     = FRAC_BITS + 2;        // folded magnitude, below 4.0
    localparam int P_W     = FRAC_BITS + 15;       // powers up to 3.14^9
    localparam int MUL_W   = P_W + 1;              // multiplier operand width
    localparam int PROD_W  = 2 * MUL_W;
    localparam int SUM_W   = P_W + 2;              // signed polynomial sum
    localparam int FACT_W  = 19;                   // 9! fits
    localparam int DIVD_W  = TRIG_W + FRAC_BITS + 1;
    localparam int DIVS_W  = TRIG_W;

    localparam int RED_STEPS = (ANGLE_W - 3 - FRAC_BITS > 0) ? (ANGLE_W - 3 - FRAC_BITS) : 1;

    localparam longint C628 = ((longint'(628) << FRAC_BITS) + 50) / 100;
    localparam longint C314 = ((longint'(314) << FRAC_BITS) + 50) / 100;

    localparam int TRIG_MAX = 2 ** (TRIG_W - 1) - 1;
    localparam int TRIG_MIN = -(2 ** (TRIG_W - 1));

    localparam longint ODD_F0  = 6;
    localparam longint ODD_F1  = 120;
    localparam longint ODD_F2  = 5040;
    localparam longint ODD_F3  = 362880;
    localparam longint EVEN_F0 = 2;
    localparam longint EVEN_F1 = 24;
    localparam longint EVEN_F2 = 720;
    localparam longint EVEN_F3 = 40320;

    // floor(2^MUL_W / d): quotient estimate is exact or one low
    localparam longint REC_ODD0  = (longint'(1) << MUL_W) / ODD_F0;
    localparam longint REC_ODD1  = (longint'(1) << MUL_W) / ODD_F1;
    localparam longint REC_ODD2  = (longint'(1) << MUL_W) / ODD_F2;
    localparam longint REC_ODD3  = (longint'(1) << MUL_W) / ODD_F3;
    localparam longint REC_EVEN0 = (longint'(1) << MUL_W) / EVEN_F0;
    localparam longint REC_EVEN1 = (longint'(1) << MUL_W) / EVEN_F1;
    localparam longint REC_EVEN2 = (longint'(1) << MUL_W) / EVEN_F2;
    localparam longint REC_EVEN3 = (longint'(1) << MUL_W) / EVEN_F3;

    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic signed [TRIG_W-1:0]  trig_t;
    typedef logic signed [TAN_W-1:0]   tan_t;

    function automatic logic [FACT_W-1:0] fact_of(input logic cos_sel, input logic [1:0] k);
        logic [FACT_W-1:0] d;
        case ({cos_sel, k})
            3'b000:  d = FACT_W'(ODD_F0);
            3'b001:  d = FACT_W'(ODD_F1);
            3'b010:  d = FACT_W'(ODD_F2);
            3'b011:  d = FACT_W'(ODD_F3);
            3'b100:  d = FACT_W'(EVEN_F0);
            3'b101:  d = FACT_W'(EVEN_F1);
            3'b110:  d = FACT_W'(EVEN_F2);
            default: d = FACT_W'(EVEN_F3);
        endcase
        return d;
    endfunction

    function automatic logic [MUL_W-1:0] recip_of(input logic cos_sel, input logic [1:0] k);
        logic [MUL_W-1:0] r;
        case ({cos_sel, k})
            3'b000:  r = MUL_W'(REC_ODD0);
            3'b001:  r = MUL_W'(REC_ODD1);
            3'b010:  r = MUL_W'(REC_ODD2);
            3'b011:  r = MUL_W'(REC_ODD3);
            3'b100:  r = MUL_W'(REC_EVEN0);
            3'b101:  r = MUL_W'(REC_EVEN1);
            3'b110:  r = MUL_W'(REC_EVEN2);
            default: r = MUL_W'(REC_EVEN3);
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### design/tsct_angle_if.sv
// Input channel: one angle item per handshake.
`timescale 1ns / 1ps
`default_nettype none

interface tsct_angle_if;
    import tsct_pkg::*;

    logic   valid;
    logic   ready;
    angle_t angle;

    modport source (output valid, output angle, input ready);
    modport sink   (input valid, input angle, output ready);
endinterface

`default_nettype wire

### design/tsct_result_if.sv
// Output channel: sine, cosine, tangent and saturation flag per item.
`timescale 1ns / 1ps
`default_nettype none

interface tsct_result_if;
    import tsct_pkg::*;

    logic  valid;
    logic  ready;
    trig_t sine_value;
    trig_t cosine_value;
    tan_t  tangent_value;
    logic  tangent_saturated;

    modport source (output valid, output sine_value, output cosine_value,
                    output tangent_value, output tangent_saturated, input ready);
    modport sink   (input valid, input sine_value, input cosine_value,
                    input tangent_value, input tangent_saturated, output ready);
endinterface

`default_nettype wire

### design/tsct_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module tsct_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tsct_pkg::DIVD_W-1:0] dividend,
    input  logic [tsct_pkg::DIVS_W-1:0] divisor,
    output logic                        done,
    output logic [tsct_pkg::DIVD_W-1:0] quotient
);
    import tsct_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [DIVS_W-1:0] dvs_reg, dvs_next;

    logic [DIVS_W:0]   shifted;
    logic [DIVS_W:0]   diff;
    logic              fits;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DIVD_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        fits      = (shifted >= {1'b0, dvs_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVD_W);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIVS_W-1:0] : shifted[DIVS_W-1:0];
            quo_next = {quo_reg[DIVD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

### design/taylor_sine_cosine_tangent_top.sv
// Top level: Taylor-series sine, cosine and tangent of one fixed-point angle.
//
//  channel   | dir | payload                                        | handshake
//  ----------+-----+------------------------------------------------+-------------
//  request   | in  | angle (Q7.14, signed 22b)                      | valid/ready
//  response  | out | sine_value, cosine_value (Q3.14, 18b),         | valid/ready
//            |     | tangent_value (Q17.14, 32b), tangent_saturated |
//
// One item at a time: 5 greedy period-reduction steps, then the sine and the
// cosine polynomial in turn on the shared multiply-add unit (setup, then 4
// terms through MUL1, MUL2, MULR, MULB, CORR and ACC), then a wait on the
// bit-serial tangent divider (33 quotient bits), skipped when the cosine is
// zero. request.ready is high only while idle.
// The result sits in an output register, so a new angle is taken while it waits.
// Reset (rst_n, async, active low) clears the sequencer and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module taylor_sine_cosine_tangent_top (
    input  logic           clk,
    input  logic           rst_n,
    tsct_angle_if.sink     request,
    tsct_result_if.source  response
);
    import tsct_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_REDUCE  = 4'd1;
    localparam logic [3:0] S_FOLD    = 4'd2;
    localparam logic [3:0] S_INIT    = 4'd3;
    localparam logic [3:0] S_MUL1    = 4'd4;
    localparam logic [3:0] S_MUL2    = 4'd5;
    localparam logic [3:0] S_MULR    = 4'd6;
    localparam logic [3:0] S_MULB    = 4'd7;
    localparam logic [3:0] S_CORR    = 4'd8;
    localparam logic [3:0] S_ACC     = 4'd9;
    localparam logic [3:0] S_FIN     = 4'd10;
    localparam logic [3:0] S_DIVGO   = 4'd11;
    localparam logic [3:0] S_DIVWAIT = 4'd12;
    localparam logic [3:0] S_TAN     = 4'd13;
    localparam logic [3:0] S_OUT     = 4'd14;

    localparam int RK_W = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
    localparam int Q_W  = ((DIVD_W > TAN_W) ? DIVD_W : TAN_W) + 1;

    localparam logic [PROD_W-1:0] RND_C   = PROD_W'(longint'(1) << (FRAC_BITS - 1));
    localparam logic [P_W-1:0]    ONE_P   = P_W'(longint'(1) << FRAC_BITS);
    localparam logic [Q_W-1:0]    POS_LIM = Q_W'((longint'(1) << (TAN_W - 1)) - 1);
    localparam logic [Q_W-1:0]    NEG_LIM = Q_W'(longint'(1) << (TAN_W - 1));

    // Sequencer and control
    logic [3:0]            state_reg, state_next;
    logic [RK_W-1:0]       red_k_reg, red_k_next;
    logic                  poly_cos_reg, poly_cos_next;
    logic [1:0]            k_reg, k_next;
    logic                  out_valid_reg, out_valid_next;

    // Datapath
    logic signed [X_W-1:0]   x_reg, x_next;
    logic [A_W-1:0]          a_sin_reg, a_sin_next;
    logic [A_W-1:0]          a_cos_reg, a_cos_next;
    logic                    sin_neg_reg, sin_neg_next;
    logic [P_W-1:0]          p_reg, p_next;
    logic [MUL_W-1:0]        n_reg, n_next;
    logic [P_W-1:0]          q0_reg, q0_next;
    logic [P_W-1:0]          term_reg, term_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    trig_t                   s_reg, s_next;
    trig_t                   c_reg, c_next;
    tan_t                    tan_reg, tan_next;
    logic                    sat_reg, sat_next;
    trig_t                   sine_out_reg, sine_out_next;
    trig_t                   cos_out_reg, cos_out_next;
    tan_t                    tan_out_reg, tan_out_next;
    logic                    sat_out_reg, sat_out_next;

    // Combinational helpers
    logic signed [X_W-1:0] red_m, red_sub, red_add;
    logic signed [X_W-1:0] c314, c314x2, xs, xc;
    logic [X_W-1:0]        xs_abs, xc_abs;
    logic [A_W-1:0]        a_cur;
    logic [FACT_W-1:0]     fact_d, half_d;
    logic [MUL_W-1:0]      recip;
    logic [MUL_W-1:0]      mul_a, mul_b;
    logic [PROD_W-1:0]     mul_c;
    logic [MUL_W-1:0]      n_cur, n_less_half, rem;
    logic                  rem_ge;
    logic signed [SUM_W-1:0] term_ext, sum_neg;
    logic [TRIG_W-1:0]     s_abs, c_abs;
    logic                  div_start, div_done;
    logic [DIVD_W-1:0]     dividend, div_quo;
    logic [Q_W-1:0]        q_ext, q_lim, q_negd;
    logic                  tan_neg, q_over;

    function automatic trig_t clamp_trig(input logic signed [SUM_W-1:0] v);
        trig_t r;
        if (v > SUM_W'(TRIG_MAX))
            r = TRIG_W'(TRIG_MAX);
        else if (v < SUM_W'(TRIG_MIN))
            r = TRIG_W'(TRIG_MIN);
        else
            r = v[TRIG_W-1:0];
        return r;
    endfunction

    // Period reduction: greedy subtraction (addition for negative angles) of C628 * 2^k, k descending
    always_comb
    begin
        red_m   = X_W'(C628) <<< red_k_reg;
        red_sub = x_reg - red_m;
        red_add = x_reg + red_m;
    end

    // Folds about C314, separate for sine and cosine
    always_comb
    begin
        c314   = X_W'(C314);
        c314x2 = X_W'(2 * C314);
        xs = x_reg;
        if (x_reg > c314)
            xs = c314 - x_reg;
        else if (x_reg < -c314)
            xs = -x_reg - c314;
        xc = x_reg;
        if (x_reg > c314)
            xc = c314x2 - x_reg;
        else if (x_reg < -c314)
            xc = x_reg + c314x2;
        xs_abs = xs[X_W-1] ? -xs : xs;
        xc_abs = xc[X_W-1] ? -xc : xc;
    end

    // Shared multiply-add operand selection
    always_comb
    begin
        a_cur  = poly_cos_reg ? a_cos_reg : a_sin_reg;
        fact_d = fact_of(poly_cos_reg, k_reg);
        half_d = fact_d >> 1;
        recip  = recip_of(poly_cos_reg, k_reg);
        mul_a  = '0;
        mul_b  = '0;
        mul_c  = '0;
        case (state_reg)
            S_MUL1:
            begin
                mul_a = MUL_W'(p_reg);
                mul_b = MUL_W'(a_cur);
                mul_c = RND_C;
            end
            S_MUL2:
            begin
                // d/2 folded in above the rounding point: gives p + d/2 directly
                mul_a = MUL_W'(prod_reg[FRAC_BITS +: P_W]);
                mul_b = MUL_W'(a_cur);
                mul_c = RND_C + (PROD_W'(half_d) << FRAC_BITS);
            end
            S_MULR:
            begin
                mul_a = prod_reg[FRAC_BITS +: MUL_W];
                mul_b = recip;
            end
            S_MULB:
            begin
                mul_a = prod_reg[MUL_W +: MUL_W];
                mul_b = MUL_W'(fact_d);
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
        prod_next = PROD_W'(mul_a) * PROD_W'(mul_b) + mul_c;
    end

    always_comb
    begin
        n_cur       = prod_reg[FRAC_BITS +: MUL_W];
        n_less_half = n_cur - MUL_W'(half_d);
        rem         = n_reg - prod_reg[MUL_W-1:0];
        rem_ge      = (rem >= MUL_W'(fact_d));
        term_ext    = $signed({2'b00, term_reg});
        sum_neg     = -sum_reg;
        s_abs       = s_reg[TRIG_W-1] ? TRIG_W'(-s_reg) : TRIG_W'(s_reg);
        c_abs       = c_reg[TRIG_W-1] ? TRIG_W'(-c_reg) : TRIG_W'(c_reg);
        dividend    = (DIVD_W'(s_abs) << FRAC_BITS) + DIVD_W'(c_abs >> 1);
        q_ext       = Q_W'(div_quo);
        tan_neg     = s_reg[TRIG_W-1] ^ c_reg[TRIG_W-1];
        q_over      = tan_neg ? (q_ext > NEG_LIM) : (q_ext > POS_LIM);
        q_lim       = q_over ? (tan_neg ? NEG_LIM : POS_LIM) : q_ext;
        q_negd      = -q_lim;
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        red_k_next     = red_k_reg;
        poly_cos_next  = poly_cos_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg & ~response.ready;
        x_next         = x_reg;
        a_sin_next     = a_sin_reg;
        a_cos_next     = a_cos_reg;
        sin_neg_next   = sin_neg_reg;
        p_next         = p_reg;
        n_next         = n_reg;
        q0_next        = q0_reg;
        term_next      = term_reg;
        sum_next       = sum_reg;
        s_next         = s_reg;
        c_next         = c_reg;
        tan_next       = tan_reg;
        sat_next       = sat_reg;
        sine_out_next  = sine_out_reg;
        cos_out_next   = cos_out_reg;
        tan_out_next   = tan_out_reg;
        sat_out_next   = sat_out_reg;
        div_start      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (request.valid)
                begin
                    x_next        = X_W'(request.angle);
                    red_k_next    = RK_W'(RED_STEPS - 1);
                    poly_cos_next = 1'b0;
                    state_next    = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                if (x_reg > 0 && red_sub > 0)
                    x_next = red_sub;
                else if (x_reg < 0 && red_add < 0)
                    x_next = red_add;
                if (red_k_reg == '0)
                    state_next = S_FOLD;
                else
                    red_k_next = red_k_reg - 1'b1;
            end
            S_FOLD:
            begin
                a_sin_next   = xs_abs[A_W-1:0];
                a_cos_next   = xc_abs[A_W-1:0];
                sin_neg_next = xs[X_W-1];
                state_next   = S_INIT;
            end
            S_INIT:
            begin
                p_next     = poly_cos_reg ? ONE_P : P_W'(a_sin_reg);
                sum_next   = poly_cos_reg ? $signed(SUM_W'(ONE_P))
                                          : $signed(SUM_W'(a_sin_reg));
                k_next     = 2'd0;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                state_next = S_MULR;
            end
            S_MULR:
            begin
                n_next     = n_cur;
                p_next     = n_less_half[P_W-1:0];
                state_next = S_MULB;
            end
            S_MULB:
            begin
                q0_next    = prod_reg[MUL_W +: P_W];
                state_next = S_CORR;
            end
            S_CORR:
            begin
                // estimate is exact or one low
                term_next  = q0_reg + P_W'(rem_ge);
                state_next = S_ACC;
            end
            S_ACC:
            begin
                sum_next = k_reg[0] ? (sum_reg + term_ext) : (sum_reg - term_ext);
                if (k_reg == 2'd3)
                    state_next = S_FIN;
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_MUL1;
                end
            end
            S_FIN:
            begin
                if (!poly_cos_reg)
                begin
                    s_next        = clamp_trig(sin_neg_reg ? sum_neg : sum_reg);
                    poly_cos_next = 1'b1;
                    state_next    = S_INIT;
                end
                else
                begin
                    c_next     = clamp_trig(sum_reg);
                    state_next = S_DIVGO;
                end
            end
            S_DIVGO:
            begin
                if (c_reg == '0)
                begin
                    tan_next   = s_reg[TRIG_W-1] ? TAN_W'(NEG_LIM) : TAN_W'(POS_LIM);
                    sat_next   = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIVWAIT;
                end
            end
            S_DIVWAIT:
            begin
                if (div_done)
                    state_next = S_TAN;
            end
            S_TAN:
            begin
                tan_next   = tan_neg ? q_negd[TAN_W-1:0] : q_lim[TAN_W-1:0];
                sat_next   = q_over;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || response.ready)
                begin
                    sine_out_next  = s_reg;
                    cos_out_next   = c_reg;
                    tan_out_next   = tan_reg;
                    sat_out_next   = sat_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            red_k_reg     <= '0;
            poly_cos_reg  <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            red_k_reg     <= red_k_next;
            poly_cos_reg  <= poly_cos_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        a_sin_reg    <= a_sin_next;
        a_cos_reg    <= a_cos_next;
        sin_neg_reg  <= sin_neg_next;
        p_reg        <= p_next;
        n_reg        <= n_next;
        q0_reg       <= q0_next;
        term_reg     <= term_next;
        sum_reg      <= sum_next;
        prod_reg     <= prod_next;
        s_reg        <= s_next;
        c_reg        <= c_next;
        tan_reg      <= tan_next;
        sat_reg      <= sat_next;
        sine_out_reg <= sine_out_next;
        cos_out_reg  <= cos_out_next;
        tan_out_reg  <= tan_out_next;
        sat_out_reg  <= sat_out_next;
    end

    // Tangent quotient: (|s| << FRAC_BITS + |c|/2) / |c|
    tsct_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (c_abs),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign request.ready              = (state_reg == S_IDLE);
    assign response.valid             = out_valid_reg;
    assign response.sine_value        = sine_out_reg;
    assign response.cosine_value      = cos_out_reg;
    assign response.tangent_value     = tan_out_reg;
    assign response.tangent_saturated = sat_out_reg;

`ifndef SYNTH
    // Reduced angle lies within one period either side of zero
    a_reduce_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FOLD |-> (x_reg <= X_W'(C628)) && (x_reg >= -X_W'(C628)))
        else $error("reduced angle outside period range");

    // Divider finishes only while the sequencer waits for it
    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIVWAIT)
        else $error("divider done outside wait state");

    // Zero cosine always flags the tangent
    a_cos_zero_sat: assert property (@(posedge clk) disable iff (!rst_n)
        response.valid && response.cosine_value == '0 |-> response.tangent_saturated)
        else $error("zero cosine without saturation flag");

    // Unsaturated nonzero tangent carries the sign of sine over cosine
    a_tan_sign: assert property (@(posedge clk) disable iff (!rst_n)
        response.valid && !response.tangent_saturated && response.tangent_value != '0
        |-> response.tangent_value[TAN_W-1] ==
            (response.sine_value[TRIG_W-1] ^ response.cosine_value[TRIG_W-1]))
        else $error("tangent sign mismatch");
`endif

endmodule

`default_nettype wire

### dv/tb_taylor_sine_cosine_tangent_top.sv
// Self-checking testbench for the Taylor sine/cosine/tangent block.
`timescale 1ns / 1ps

module tb_taylor_sine_cosine_tangent_top;
    import tsct_pkg::*;

    // Fixed-point setup: the block folds with 6.28 and 3.14 taken as decimals,
    // each rounded to nearest at FB fraction bits (not true pi).
    localparam int     FB          = tsct_pkg::FRAC_BITS;
    localparam longint PERIOD_Q    = ((longint'(628) << FB) + 50) / 100;
    localparam longint HALF_Q      = ((longint'(314) << FB) + 50) / 100;
    localparam longint TRIG_HI     = (longint'(1) << (TRIG_W - 1)) - 1;
    localparam longint TRIG_LO     = -(longint'(1) << (TRIG_W - 1));
    localparam longint TAN_HI      = (longint'(1) << (TAN_W - 1)) - 1;
    localparam longint TAN_LO_MAG  = longint'(1) << (TAN_W - 1);

    // Run control
    localparam int RANDOM_ITEMS = 1430;
    localparam int DRAIN_CYCLES = 250;   // extra wait after the last expected result
    localparam int IDLE_LIMIT   = 4000;  // cycles with no handshake on either side

    typedef struct {
        angle_t angle;
        trig_t  sine;
        trig_t  cosine;
        tan_t   tangent;
        logic   saturated;
    } trig_item_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    tsct_angle_if  request_ch ();
    tsct_result_if response_ch ();

    taylor_sine_cosine_tangent_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_ch),
        .response (response_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Angles waiting to be sent, and trig results still owed by the block.
    angle_t     angle_backlog[$];
    trig_item_t trig_due[$];

    int fault_count = 0;
    int burst_left;
    int gap_left;
    int hold_left;
    int quiet_cycles;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Q-format product, rounded to nearest with ties upward (operands >= 0).
    function automatic longint rnd_mul(input longint a, input longint b);
        return (a * b + (longint'(1) << (FB - 1))) >> FB;
    endfunction

    function automatic longint clamp_trig(input longint v);
        if (v > TRIG_HI)
            return TRIG_HI;
        if (v < TRIG_LO)
            return TRIG_LO;
        return v;
    endfunction

    function automatic trig_item_t taylor_trig(input angle_t ang);
        longint     x;
        longint     xs;
        longint     xc;
        longint     mag;
        longint     pw;
        longint     dv;
        longint     term;
        longint     s;
        longint     c;
        longint     num;
        longint     den;
        longint     q;
        longint     t;
        logic       sat;
        int         k;
        trig_item_t r;

        // Greedy period reduction into [-6.28, 6.28]
        x = longint'(ang);
        while (x > PERIOD_Q)
            x -= PERIOD_Q;
        while (x < -PERIOD_Q)
            x += PERIOD_Q;

        // Sine and cosine fold about 3.14 in different ways
        xs = x;
        xc = x;
        if (xs > HALF_Q)
            xs = HALF_Q - xs;
        else if (xs < -HALF_Q)
            xs = -xs - HALF_Q;
        if (xc > HALF_Q)
            xc = 2 * HALF_Q - xc;
        else if (xc < -HALF_Q)
            xc = xc + 2 * HALF_Q;

        // Odd series on |x|: x - x^3/3! + x^5/5! - x^7/7! + x^9/9!, sign restored
        mag = (xs < 0) ? -xs : xs;
        pw  = mag;
        s   = mag;
        dv  = 1;
        for (k = 0; k < 4; k++)
        begin
            pw   = rnd_mul(rnd_mul(pw, mag), mag);
            dv   = dv * (2 * k + 2) * (2 * k + 3);
            term = (pw + dv / 2) / dv;
            s    = (k % 2 == 1) ? s + term : s - term;
        end
        if (xs < 0)
            s = -s;

        // Even series on |x|: 1 - x^2/2! + x^4/4! - x^6/6! + x^8/8!
        mag = (xc < 0) ? -xc : xc;
        pw  = longint'(1) << FB;
        c   = pw;
        dv  = 1;
        for (k = 0; k < 4; k++)
        begin
            pw   = rnd_mul(rnd_mul(pw, mag), mag);
            dv   = dv * (2 * k + 1) * (2 * k + 2);
            term = (pw + dv / 2) / dv;
            c    = (k % 2 == 1) ? c + term : c - term;
        end

        s = clamp_trig(s);
        c = clamp_trig(c);

        // Tangent: rounded quotient, ties away from zero, saturated
        sat = 1'b0;
        if (c == 0)
        begin
            sat = 1'b1;
            t   = (s >= 0) ? TAN_HI : -TAN_LO_MAG;
        end
        else
        begin
            num = ((s < 0) ? -s : s) << FB;
            den = (c < 0) ? -c : c;
            q   = (num + den / 2) / den;
            if ((s < 0) != (c < 0))
            begin
                if (q > TAN_LO_MAG)
                begin
                    q   = TAN_LO_MAG;
                    sat = 1'b1;
                end
                t = -q;
            end
            else
            begin
                if (q > TAN_HI)
                begin
                    q   = TAN_HI;
                    sat = 1'b1;
                end
                t = q;
            end
        end

        r.angle     = ang;
        r.sine      = trig_t'(s);
        r.cosine    = trig_t'(c);
        r.tangent   = tan_t'(t);
        r.saturated = sat;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Angle driver: bursts of random length, random gaps after each burst.
    // The expected result is computed when the block takes the angle.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            request_ch.valid <= 1'b0;
            request_ch.angle <= '0;
            burst_left       <= 0;
            gap_left         <= 0;
        end
        else
        begin
            if (request_ch.valid && request_ch.ready)
                trig_due.push_back(taylor_trig(request_ch.angle));

            // The channel is free when nothing is offered or the offer was just taken
            if (!request_ch.valid || request_ch.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left         <= gap_left - 1;
                    request_ch.valid <= 1'b0;
                end
                else if (angle_backlog.size() != 0)
                begin
                    request_ch.valid <= 1'b1;
                    request_ch.angle <= angle_backlog.pop_front();
                    if (burst_left <= 1)
                    begin
                        // Last item of a burst; a gap may follow
                        burst_left <= $urandom_range(1, 10);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 130);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    request_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and receiver stall pattern
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        trig_item_t want;

        if (!rst_n)
        begin
            response_ch.ready <= 1'b0;
            hold_left         <= 0;
        end
        else
        begin
            if (response_ch.valid && response_ch.ready)
            begin
                if (trig_due.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("%0t: unexpected result: sin %0d cos %0d tan %0d sat %0b",
                                 $realtime, response_ch.sine_value, response_ch.cosine_value,
                                 response_ch.tangent_value, response_ch.tangent_saturated);
                end
                else
                begin
                    want = trig_due.pop_front();
                    if (response_ch.sine_value !== want.sine
                        || response_ch.cosine_value !== want.cosine
                        || response_ch.tangent_value !== want.tangent
                        || response_ch.tangent_saturated !== want.saturated)
                    begin
                        fault_count++;
                        // each pair is expected/actual
                        if (fault_count <= 10)
                            $display(
                                "%0t: ang %0d sin %0d/%0d cos %0d/%0d tan %0d/%0d sat %0b/%0b",
                                $realtime, want.angle,
                                want.sine, response_ch.sine_value,
                                want.cosine, response_ch.cosine_value,
                                want.tangent, response_ch.tangent_value,
                                want.saturated, response_ch.tangent_saturated);
                    end
                end
            end

            // Stall pattern: long open stretches, short stalls, long stalls, coin flips
            if (hold_left != 0)
                hold_left <= hold_left - 1;
            else
            begin
                case ($urandom_range(0, 7))
                    0, 1, 2:
                    begin
                        response_ch.ready <= 1'b1;
                        hold_left         <= $urandom_range(20, 300);
                    end
                    3, 4:
                    begin
                        response_ch.ready <= 1'b0;
                        hold_left         <= $urandom_range(1, 8);
                    end
                    5:
                    begin
                        response_ch.ready <= 1'b0;
                        hold_left         <= $urandom_range(30, 150);
                    end
                    default:
                        response_ch.ready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: a run with no handshake for too long is a hang
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((request_ch.valid && request_ch.ready)
                 || (response_ch.valid && response_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        trig_item_t probe;
        int         cos_zero[4];
        longint     best_mag[2];
        longint     mag;
        int         lo;
        int         hi;
        int         w;
        int         x;
        int         n;
        int         pick;
        int         turns;
        int         a;

        // Find the angles nearest a quarter and three quarters of a turn where
        // the cosine series lands on zero (or closest to it): the tangent has
        // to take its divide-by-zero path there.
        for (w = 0; w < 2; w++)
        begin
            lo          = (w == 0) ? 24000 : 75000;
            hi          = (w == 0) ? 27500 : 79500;
            best_mag[w] = TRIG_HI;
            cos_zero[w] = lo;
            for (x = lo; x <= hi; x++)
            begin
                probe = taylor_trig(angle_t'(x));
                mag   = (probe.cosine < 0) ? -longint'(probe.cosine) : longint'(probe.cosine);
                if (mag < best_mag[w])
                begin
                    best_mag[w] = mag;
                    cos_zero[w] = x;
                end
            end
        end
        cos_zero[2] = -cos_zero[0];
        cos_zero[3] = -cos_zero[1];

        // Directed: zero, unit steps, field extremes, fold and period boundaries
        angle_backlog.push_back(angle_t'(0));
        angle_backlog.push_back(angle_t'(1));
        angle_backlog.push_back(angle_t'(-1));
        angle_backlog.push_back(angle_t'(2097151));
        angle_backlog.push_back(angle_t'(-2097152));
        angle_backlog.push_back(angle_t'(PERIOD_Q));
        angle_backlog.push_back(angle_t'(-PERIOD_Q));
        angle_backlog.push_back(angle_t'(PERIOD_Q + 1));
        angle_backlog.push_back(angle_t'(-PERIOD_Q - 1));
        angle_backlog.push_back(angle_t'(HALF_Q));
        angle_backlog.push_back(angle_t'(-HALF_Q));
        angle_backlog.push_back(angle_t'(HALF_Q + 1));
        angle_backlog.push_back(angle_t'(-HALF_Q - 1));
        angle_backlog.push_back(angle_t'(longint'(1) << FB));
        angle_backlog.push_back(angle_t'(-(longint'(1) << FB)));
        angle_backlog.push_back(angle_t'(22'h155555));
        angle_backlog.push_back(angle_t'(22'h2AAAAA));
        // Cosine at (or nearest) zero, both signs, and one far-out alias
        for (n = 0; n < 4; n++)
            angle_backlog.push_back(angle_t'(cos_zero[n]));
        angle_backlog.push_back(angle_t'(cos_zero[0] + 19 * PERIOD_Q));

        // Random part: full-range angles toggle every bit, small angles skip
        // most of the reduction, and the rest sit near fold boundaries or
        // near the cosine zeros, aliased by whole periods.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick  = $urandom_range(0, 9);
            turns = int'($urandom_range(0, 38)) - 19;
            case (pick)
                0, 1, 2, 3, 4:
                    a = int'(angle_t'($urandom));
                5, 6:
                    a = int'($urandom_range(0, 4 * PERIOD_Q)) - 2 * int'(PERIOD_Q);
                7:
                    a = turns * int'(PERIOD_Q)
                        + (int'($urandom_range(0, 2)) - 1) * int'(HALF_Q)
                        + int'($urandom_range(0, 6)) - 3;
                default:
                    a = cos_zero[$urandom_range(0, 3)] + turns * int'(PERIOD_Q)
                        + int'($urandom_range(0, 8)) - 4;
            endcase
            angle_backlog.push_back(angle_t'(a));
        end

        // Single reset at the start of the run
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Sampled away from the active edge so queue updates have settled
        while (angle_backlog.size() != 0 || request_ch.valid || trig_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
